// File: rtl/ist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants for the inventory seen table
// Entry, request and response layouts, cell control group, sequencer states.
// ----------------------------------------------------------------------------
package ist_pkg;

    // table geometry
    localparam int CAPACITY  = 64;
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W     = 7;
    localparam int GRP_SIZE  = 8;
    localparam int GRP_NUM   = CAPACITY / GRP_SIZE;
    localparam int GRP_CNT_W = $clog2(GRP_SIZE + 1);

    // default expiry: ten minutes in milliseconds
    localparam logic [31:0] EXPIRY_RESET = 32'd600000;

    // action codes
    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_EXPIRE = 2'd2;

    // input transaction
    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] hash_w0;
        logic [63:0] hash_w1;
        logic [63:0] hash_w2;
        logic [63:0] hash_w3;
        logic [31:0] item_type;
        logic [63:0] now_ms;
    } t_req;

    // output transaction
    typedef struct packed {
        logic             found;
        logic             evicted;
        logic [OCC_W-1:0] removed;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    // one stored entry
    typedef struct packed {
        logic [63:0] hash_w0;
        logic [63:0] hash_w1;
        logic [63:0] hash_w2;
        logic [63:0] hash_w3;
        logic [31:0] kind;
        logic [63:0] stamp;
    } t_entry;

    // broadcast control for the cell row
    typedef struct packed {
        logic cmp;    // capture match and age flags
        logic shift;  // evict oldest: every cell takes its right neighbor
        logic load;   // selected cell takes the new entry
        logic drop;   // invalidate aged-out cells
        logic pack;   // close holes toward the head of the row
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ACT,
        ST_PACK,
        ST_HOLD
    } t_state;

endpackage

// File: rtl/ist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_cell: one slot of the seen table
// Holds one entry, compares it against the request, and trades contents with
// its neighbors for eviction shifts and hole compaction.
// ----------------------------------------------------------------------------
module ist_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ist_pkg::t_cell_ctl i_ctl,
    input  logic               i_sel,
    input  ist_pkg::t_entry    i_key,
    input  logic [31:0]        i_expiry,
    input  ist_pkg::t_entry    i_right_entry,
    input  logic               i_right_valid,
    input  logic               i_left_valid,
    output ist_pkg::t_entry    o_entry,
    output logic               o_valid,
    output logic               o_match,
    output logic               o_doom,
    output logic               o_move
);
    import ist_pkg::*;

    t_entry      r_entry;
    t_entry      n_entry;
    logic        r_valid;
    logic        n_valid;
    logic        r_match;
    logic        r_doom;
    logic        w_eq;
    logic [63:0] w_age;
    logic        w_take;

    // key compare and age against the request time
    assign w_eq = (r_entry.kind == i_key.kind) && (r_entry.hash_w0 == i_key.hash_w0) &&
                  (r_entry.hash_w1 == i_key.hash_w1) && (r_entry.hash_w2 == i_key.hash_w2) &&
                  (r_entry.hash_w3 == i_key.hash_w3);
    assign w_age = i_key.stamp - r_entry.stamp;

    // a hole pulls in a live right neighbor
    assign w_take = !r_valid && i_right_valid;

    // next contents
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_entry = i_right_entry;
        end
        if (i_ctl.load && i_sel) begin
            n_entry = i_key;
            n_valid = 1'b1;
        end
        if (i_ctl.drop) begin
            n_valid = r_valid && !r_doom;
        end
        if (i_ctl.pack) begin
            if (w_take) begin
                n_entry = i_right_entry;
                n_valid = 1'b1;
            end else if (r_valid && !i_left_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload and compare flags
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp) begin
            r_match <= r_valid && w_eq;
            r_doom  <= r_valid && (w_age >= {32'd0, i_expiry});
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_doom  = r_doom;
    assign o_move  = w_take;

endmodule

// File: rtl/inventory_seen_table.sv
`timescale 1ns / 1ps
// Query and add: request registered on acceptance in the idle state, then a compare
// state and an act state that registers the result (a hold state waits on a stall).
// Expire: act drops aged-out cells; compaction then moves each entry at most one cell
// per cycle, and the result registers once no cell moves and the output is free.
// One item in flight at a time. Synchronous active-low reset empties the table
// (per-cell valid bits) and restores the 600000 ms expiry.
// ----------------------------------------------------------------------------
// inventory_seen_table: bounded insertion-ordered set of inventory items
// A row of cells holds the entries; a small sequencer broadcasts compare,
// evict-shift, load, drop and compaction steps and counts occupancy.
// ----------------------------------------------------------------------------
module inventory_seen_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ist_pkg::t_req   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ist_pkg::t_rsp   o_out_data,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata
);
    import ist_pkg::*;

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    logic [31:0]           r_expiry;
    logic                  r_found;
    t_rsp                  r_res;
    t_rsp                  n_res;
    t_rsp                  r_out;
    logic                  r_out_valid;
    logic [GRP_CNT_W-1:0]  r_grp_cnt [GRP_NUM];

    t_entry                w_key;
    t_cell_ctl             w_ctl;
    t_entry                w_entry [CAPACITY];
    logic [CAPACITY-1:0]   w_cvalid;
    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY-1:0]   w_doom;
    logic [CAPACITY-1:0]   w_move;
    logic [CAPACITY-1:0]   w_sel;
    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_found;
    logic                  w_full;
    logic                  w_add_new;
    logic                  w_any_move;
    logic                  w_out_load;
    logic [OCC_W-1:0]      w_removed;

    // handshake
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // request as an entry; stamp doubles as the reference time
    always_comb begin
        w_key.hash_w0 = r_req.hash_w0;
        w_key.hash_w1 = r_req.hash_w1;
        w_key.hash_w2 = r_req.hash_w2;
        w_key.hash_w3 = r_req.hash_w3;
        w_key.kind    = r_req.item_type;
        w_key.stamp   = r_req.now_ms;
    end

    // cell row
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_entry w_right_entry;
        logic   w_right_valid;
        logic   w_left_valid;

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right_entry = w_key;
            assign w_right_valid = 1'b0;
        end else begin : g_body
            assign w_right_entry = w_entry[gi+1];
            assign w_right_valid = w_cvalid[gi+1];
        end

        if (gi == 0) begin : g_head
            assign w_left_valid = 1'b1;
        end else begin : g_rest
            assign w_left_valid = w_cvalid[gi-1];
        end

        assign w_sel[gi] = (r_fill == FILL_W'(gi));

        ist_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_sel         (w_sel[gi]),
            .i_key         (w_key),
            .i_expiry      (r_expiry),
            .i_right_entry (w_right_entry),
            .i_right_valid (w_right_valid),
            .i_left_valid  (w_left_valid),
            .o_entry       (w_entry[gi]),
            .o_valid       (w_cvalid[gi]),
            .o_match       (w_match[gi]),
            .o_doom        (w_doom[gi]),
            .o_move        (w_move[gi])
        );
    end

    // row summaries
    assign w_found    = |w_match;
    assign w_any_move = |w_move;
    assign w_full     = (r_fill == FILL_W'(CAPACITY));
    assign w_add_new  = (r_req.action == ACT_ADD) && !w_found;

    // removed count from registered group counts
    always_comb begin
        w_removed = '0;
        for (int g = 0; g < GRP_NUM; g++) begin
            w_removed = w_removed + OCC_W'(r_grp_cnt[g]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_ACT;
            end
            ST_ACT: begin
                if (r_req.action == ACT_EXPIRE) begin
                    n_state = ST_PACK;
                end else if (w_slot_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_PACK: begin
                if (!w_any_move && w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs: cell control, fill update, result
    always_comb begin
        w_ctl      = '0;
        n_fill     = r_fill;
        n_res      = r_res;
        w_out_load = 1'b0;
        case (r_state)
            ST_CMP: begin
                w_ctl.cmp = 1'b1;
            end
            ST_ACT: begin
                w_ctl.shift = w_add_new && w_full;
                w_ctl.load  = w_add_new && !w_full;
                w_ctl.drop  = (r_req.action == ACT_EXPIRE);
                if (w_add_new && !w_full) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                n_res.found     = w_found;
                n_res.evicted   = w_add_new && w_full;
                n_res.removed   = '0;
                n_res.occupancy = OCC_W'(n_fill);
                w_out_load      = (r_req.action != ACT_EXPIRE) && w_slot_free;
            end
            ST_PACK: begin
                w_ctl.pack = 1'b1;
                if (!w_any_move && w_slot_free) begin
                    n_fill          = r_fill - FILL_W'(w_removed);
                    n_res.found     = r_found;
                    n_res.evicted   = 1'b0;
                    n_res.removed   = w_removed;
                    n_res.occupancy = OCC_W'(n_fill);
                    w_out_load      = 1'b1;
                end
            end
            ST_HOLD: begin
                w_out_load = w_slot_free;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_expiry    <= EXPIRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                r_expiry <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        r_res <= n_res;
        if (r_state == ST_ACT) begin
            r_found <= w_found;
            for (int g = 0; g < GRP_NUM; g++) begin
                r_grp_cnt[g] <= GRP_CNT_W'($countones(w_doom[g*GRP_SIZE +: GRP_SIZE]));
            end
        end
        if (w_out_load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for inventory_seen_table
// A scoreboard class predicts found, evicted, removed and occupancy for every
// accepted transaction and compares them with the block's results in order.
// The stimulus is a directed opener followed by randomized phases under
// several expiry settings, with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import ist_pkg::*;

    // action code with no defined operation
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // hash plus type, the identity of one inventory item
    typedef struct packed {
        logic [255:0] hash;
        logic [31:0]  kind;
    } t_key;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the seen table and the replies still owed
    // ------------------------------------------------------------------------
    class seen_table_scoreboard;
        t_entry      rows [CAPACITY];
        int          fill;
        logic [31:0] expiry;
        t_rsp        pending_replies [$];
        int          errors;

        function new();
            fill   = 0;
            expiry = EXPIRY_RESET;
            errors = 0;
        endfunction

        function void set_expiry(logic [31:0] value);
            expiry = value;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // update the mirror for one accepted transaction, queue its reply
        function void predict_reply(t_req r);
            t_rsp        reply;
            int          keep;
            logic [63:0] age;
            reply = '0;
            for (int i = 0; i < fill; i++) begin
                if (rows[i].hash_w0 == r.hash_w0 && rows[i].hash_w1 == r.hash_w1 &&
                    rows[i].hash_w2 == r.hash_w2 && rows[i].hash_w3 == r.hash_w3 &&
                    rows[i].kind == r.item_type)
                    reply.found = 1'b1;
            end
            case (r.action)
                ACT_ADD: begin
                    if (!reply.found) begin
                        // full table: oldest entry goes first
                        if (fill >= CAPACITY) begin
                            for (int i = 0; i < CAPACITY - 1; i++)
                                rows[i] = rows[i + 1];
                            fill = CAPACITY - 1;
                            reply.evicted = 1'b1;
                        end
                        rows[fill].hash_w0 = r.hash_w0;
                        rows[fill].hash_w1 = r.hash_w1;
                        rows[fill].hash_w2 = r.hash_w2;
                        rows[fill].hash_w3 = r.hash_w3;
                        rows[fill].kind    = r.item_type;
                        rows[fill].stamp   = r.now_ms;
                        fill++;
                    end
                end
                ACT_EXPIRE: begin
                    // keep young entries in order; age wraps modulo 2^64
                    keep = 0;
                    for (int i = 0; i < fill; i++) begin
                        age = r.now_ms - rows[i].stamp;
                        if (age < {32'd0, expiry}) begin
                            rows[keep] = rows[i];
                            keep++;
                        end
                    end
                    reply.removed = OCC_W'(fill - keep);
                    fill = keep;
                end
                default: begin
                end
            endcase
            reply.occupancy = OCC_W'(fill);
            pending_replies.push_back(reply);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result with the oldest reply owed
        function void check_reply(t_rsp got);
            t_rsp want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("found", 8'(want.found), 8'(got.found));
            compare_field("evicted", 8'(want.evicted), 8'(got.evicted));
            compare_field("removed", 8'(want.removed), 8'(got.removed));
            compare_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_req        in_data;
    logic        out_valid;
    logic        out_stall;
    t_rsp        out_data;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    // no-idle stretches per phase
    bit calm_in;
    bit calm_out;

    seen_table_scoreboard table_sb = new();
    t_key                 key_pool [$];

    inventory_seen_table uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // known values from time zero
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b1;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        calm_in   = 1'b0;
        calm_out  = 1'b0;
    end

    // transaction monitor: check results, predict accepted requests
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                table_sb.check_reply(out_data);
            if (in_valid && !in_stall)
                table_sb.predict_reply(in_data);
        end
    end

    // result side: random stall before taking each result
    initial begin : result_sink
        int hold;
        @(posedge rst_n);
        forever begin
            hold = calm_out ? 0 : $urandom_range(0, 13);
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // hard limit on run time
    initial begin
        #(20_000_000);
        $display("FAIL inventory_seen_table");
        $finish;
    end

    function automatic t_req make_req(logic [1:0] act, t_key k, logic [63:0] now);
        t_req r;
        r.action    = act;
        r.hash_w0   = k.hash[63:0];
        r.hash_w1   = k.hash[127:64];
        r.hash_w2   = k.hash[191:128];
        r.hash_w3   = k.hash[255:192];
        r.item_type = k.kind;
        r.now_ms    = now;
        return r;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.hash = {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        k.kind = $urandom;
        return k;
    endfunction

    function automatic t_key pool_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // same as a known key except for one bit of hash or type
    function automatic t_key near_miss(t_key k);
        int b;
        b = $urandom_range(0, 287);
        if (b < 256)
            k.hash[b] = ~k.hash[b];
        else
            k.kind[b - 256] = ~k.kind[b - 256];
        return k;
    endfunction

    // present one transaction after a random gap, hold until accepted
    task automatic drive_item(t_req r);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // drain: no request pending and every reply received
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_expiry(logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        table_sb.set_expiry(value);
    endtask

    // main stimulus
    initial begin
        t_key        key_ones;
        t_key        key_zero;
        t_key        k;
        t_key        k_type0;
        logic [1:0]  act;
        logic [63:0] now_cursor;
        logic [31:0] expiry_val;
        int unsigned step_max;
        int          add_pct;
        int          roll;

        key_ones = '1;
        key_zero = '0;
        k_type0  = key_ones;
        k_type0.kind = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opener at the reset expiry of ten minutes
        drive_item(make_req(ACT_QUERY, key_zero, 64'd0));     // empty table
        drive_item(make_req(ACT_ADD, key_ones, 64'd0));
        drive_item(make_req(ACT_QUERY, key_ones, 64'd1));
        drive_item(make_req(ACT_ADD, key_ones, 64'd2));       // duplicate add
        drive_item(make_req(ACT_ADD, key_zero, 64'd100));
        drive_item(make_req(ACT_QUERY, k_type0, 64'd101));    // hash hit, type miss
        drive_item(make_req(ACT_UNUSED, key_zero, 64'd102));
        drive_item(make_req(ACT_EXPIRE, key_ones, 64'd599999)); // just below limit
        drive_item(make_req(ACT_EXPIRE, key_zero, 64'd600000)); // exactly at limit
        drive_item(make_req(ACT_EXPIRE, key_zero, 64'd50));   // time goes backwards
        drive_item(make_req(ACT_ADD, key_ones, '1));
        drive_item(make_req(ACT_EXPIRE, key_ones, 64'd0));    // forward across wrap
        settle();

        // zero expiry: everything ages out
        write_expiry(32'd0);
        drive_item(make_req(ACT_ADD, key_zero, 64'd5));
        drive_item(make_req(ACT_ADD, key_ones, 64'd5));
        drive_item(make_req(ACT_EXPIRE, key_zero, 64'd5));
        settle();

        // randomized phases, each with its own expiry and time base
        for (int p = 0; p < 9; p++) begin
            add_pct = 50;
            case (p)
                0: begin
                    expiry_val = 32'hFFFF_FFFF;
                    step_max   = 3;
                    add_pct    = 70;
                end
                1: begin
                    expiry_val = 32'd1;
                    step_max   = 2;
                end
                2: begin
                    expiry_val = EXPIRY_RESET;
                    step_max   = 40000;
                end
                3: begin
                    expiry_val = 32'hFFFF_FFFF;
                    step_max   = 100;
                    add_pct    = 65;
                end
                7: begin
                    expiry_val = $urandom;
                    step_max   = $urandom;
                end
                default: begin
                    step_max   = $urandom_range(1, 5000);
                    expiry_val = $urandom_range(step_max * 4, step_max * 60);
                end
            endcase
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            write_expiry(expiry_val);
            now_cursor = {$urandom, $urandom};

            for (int n = 0; n < 150; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < add_pct)
                    act = ACT_ADD;
                else if (roll < add_pct + 25)
                    act = ACT_QUERY;
                else if (roll < add_pct + 29)
                    act = ACT_UNUSED;
                else
                    act = ACT_EXPIRE;

                // known keys, some near misses, some fresh ones; adds mostly take fresh keys
                roll = $urandom_range(0, 99);
                if (key_pool.size() == 0)
                    k = random_key();
                else if (act == ACT_ADD)
                    k = (roll < 30) ? pool_key() : random_key();
                else if (roll < 55)
                    k = pool_key();
                else if (roll < 75)
                    k = near_miss(pool_key());
                else
                    k = random_key();
                if (act == ACT_ADD) begin
                    key_pool.push_back(k);
                    if (key_pool.size() > 100)
                        void'(key_pool.pop_front());
                end

                // time mostly moves forward, now and then it steps back
                if ($urandom_range(0, 99) < 3)
                    now_cursor = now_cursor - 64'($urandom_range(1, 1000));
                else
                    now_cursor = now_cursor + 64'($urandom_range(0, step_max));

                drive_item(make_req(act, k, now_cursor));
            end
            settle();
        end

        // back to the reset setting before the end
        write_expiry(EXPIRY_RESET);
        settle();
        repeat (CAPACITY + 16) @(posedge clk);

        if (table_sb.errors == 0 && table_sb.pending() == 0)
            $display("PASS inventory_seen_table");
        else
            $display("FAIL inventory_seen_table");
        $finish;
    end

endmodule

// File: files.f
rtl/ist_pkg.sv
rtl/ist_cell.sv
rtl/inventory_seen_table.sv
verif/testbench.sv
